FILE: sv/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

   localparam int DEPTH       = 16;
   localparam int AW          = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int POS_W       = 16;
   localparam int HANDLE_W    = 32;
   localparam int FOUND_W     = 5;
   localparam int COUNT_OUT_W = 5;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_FIND   = 2'd3
   } ils_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } ils_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INS_WR,
      S_READ_RD,
      S_READ_WAIT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DONE
   } ils_state_type;

   typedef struct packed {
      ils_op_type                op;
      logic signed [POS_W-1:0]   position;
      logic [HANDLE_W-1:0]       handle;
   } ils_item_type;

   typedef struct packed {
      logic [HANDLE_W-1:0]       read_value;
      logic [FOUND_W-1:0]        found_position;
      logic                      hit;
      logic [COUNT_OUT_W-1:0]    entry_count;
      ils_status_type            status;
   } ils_rsp_type;

   typedef struct packed {
      logic                      we;
      logic [AW-1:0]             waddr;
      logic [HANDLE_W-1:0]       wdata;
      logic                      re;
      logic [AW-1:0]             raddr;
   } ils_mem_req_type;

endpackage

FILE: sv/ils_mem.sv
`timescale 1ns / 1ps

module ils_mem
   import ils_pkg::*;
(
   input  logic                clock,
   input  ils_mem_req_type     mem_req,
   output logic [HANDLE_W-1:0] rdata
);

   logic [HANDLE_W-1:0] mem_ff [DEPTH];
   logic [HANDLE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= mem_ff[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/ils_ctrl.sv
`timescale 1ns / 1ps

module ils_ctrl
   import ils_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ils_item_type        item,
   input  logic                out_free,
   output logic                done,
   output ils_rsp_type         result,
   output ils_mem_req_type     mem_req,
   input  logic [HANDLE_W-1:0] rdata
);

   ils_state_type       state_ff, state_in;
   ils_op_type          op_ff;
   logic [AW-1:0]       idx_ff;
   logic [AW-1:0]       at_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [HANDLE_W-1:0] rval_ff;
   logic [FOUND_W-1:0]  found_ff;
   logic                hit_ff;
   ils_status_type      status_ff;

   logic                accept;
   logic                empty;
   logic                full;
   logic                pos_le0;
   logic                pos_ge;
   logic                pos_ge_last;
   logic [AW-1:0]       ins_at;
   logic [AW-1:0]       ex_at;
   logic [AW-1:0]       idx_dec;
   logic [AW-1:0]       idx_inc;
   logic [CNT_W-1:0]    idx_next_cnt;
   logic                match;

   assign accept  = req_tvalid && req_tready;
   assign empty   = (count_ff == '0);
   assign full    = (count_ff >= CNT_W'(DEPTH));
   assign pos_le0 = (item.position <= 0);
   assign pos_ge  = ($unsigned(item.position) >= POS_W'(count_ff));
   // position at or past the last existing entry
   assign pos_ge_last = ($unsigned(item.position) >= POS_W'(count_ff - 1'b1));

   assign ins_at = pos_le0 ? '0 : (pos_ge ? AW'(count_ff) : AW'(item.position));
   assign ex_at  = pos_le0 ? '0 :
                   (pos_ge_last ? AW'(count_ff - 1'b1) : AW'(item.position));

   // shared index unit: step and compare against the count
   assign idx_dec      = idx_ff - 1'b1;
   assign idx_inc      = idx_ff + 1'b1;
   assign idx_next_cnt = CNT_W'(idx_ff) + 1'b1;
   assign match        = (rdata == handle_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (item.op)
                  OP_INSERT: begin
                     if (full) begin
                        state_in = S_DONE;
                     end else if (count_ff > CNT_W'(ins_at)) begin
                        state_in = S_SHIFT_RD;
                     end else begin
                        state_in = S_INS_WR;
                     end
                  end
                  OP_REMOVE: begin
                     if (empty) begin
                        state_in = S_DONE;
                     end else if (CNT_W'(ex_at) + 1'b1 < count_ff) begin
                        state_in = S_SHIFT_RD;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  OP_READ:  state_in = empty ? S_DONE : S_READ_RD;
                  OP_FIND:  state_in = empty ? S_DONE : S_SCAN_RD;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            if (op_ff == OP_INSERT) begin
               state_in = (idx_dec == at_ff) ? S_INS_WR : S_SHIFT_RD;
            end else begin
               // count already holds the reduced value here
               state_in = (idx_next_cnt == count_ff) ? S_DONE : S_SHIFT_RD;
            end
         end
         S_INS_WR:    state_in = S_DONE;
         S_READ_RD:   state_in = S_READ_WAIT;
         S_READ_WAIT: state_in = S_DONE;
         S_SCAN_RD:   state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (match || idx_next_cnt == count_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      done          = 1'b0;
      mem_req.we    = 1'b0;
      mem_req.waddr = idx_ff;
      mem_req.wdata = rdata;
      mem_req.re    = 1'b0;
      mem_req.raddr = idx_ff;
      case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_SHIFT_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = (op_ff == OP_INSERT) ? idx_dec : idx_inc;
         end
         S_SHIFT_WR: mem_req.we = 1'b1;
         S_INS_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = at_ff;
            mem_req.wdata = handle_ff;
         end
         S_READ_RD: mem_req.re = 1'b1;
         S_SCAN_RD: mem_req.re = 1'b1;
         S_DONE:    done = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && item.op == OP_REMOVE && !empty) begin
            count_ff <= count_ff - 1'b1;
         end else if (state_ff == S_INS_WR) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_ff     <= item.op;
               handle_ff <= item.handle;
               at_ff     <= ins_at;
               rval_ff   <= '0;
               hit_ff    <= 1'b0;
               found_ff  <= '0;
               status_ff <= ST_OK;
               case (item.op)
                  OP_INSERT: begin
                     idx_ff <= AW'(count_ff);
                     if (full) begin
                        status_ff <= ST_FULL;
                     end
                  end
                  OP_FIND: begin
                     idx_ff   <= '0;
                     found_ff <= '1;
                     if (empty) begin
                        status_ff <= ST_EMPTY;
                     end
                  end
                  default: begin
                     idx_ff <= ex_at;
                     if (empty) begin
                        status_ff <= ST_EMPTY;
                     end
                  end
               endcase
            end
         end
         S_SHIFT_WR: idx_ff <= (op_ff == OP_INSERT) ? idx_dec : idx_inc;
         S_READ_WAIT: begin
            rval_ff <= rdata;
            hit_ff  <= 1'b1;
         end
         S_SCAN_CMP: begin
            if (match) begin
               hit_ff   <= 1'b1;
               found_ff <= FOUND_W'(idx_ff);
            end else begin
               idx_ff <= idx_inc;
            end
         end
         default: begin
         end
      endcase
   end

   assign result.read_value     = rval_ff;
   assign result.found_position = found_ff;
   assign result.hit            = hit_ff;
   assign result.entry_count    = COUNT_OUT_W'(count_ff);
   assign result.status         = status_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      mem_req.re |-> CNT_W'(mem_req.raddr) <= count_ff)
      else $error("read beyond the stored entries");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1)
                 || (count_ff == $past(count_ff) - 1'b1))
      else $error("count moved by more than one");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer idle right after a beat");
`endif

endmodule

FILE: sv/indexed_list_store.sv
`timescale 1ns / 1ps

// Ordered list of up to DEPTH 32-bit handles held in a simple dual-port RAM
// (one write and one registered read per cycle) and worked by one sequencer
// with a shared index/compare unit. One beat is handled at a time: req_tready
// is high only while the sequencer is idle. Insert and remove move one entry
// at a time, reading it and then writing it one place over; find reads and
// compares one entry at a time and stops at the first match; read reads the
// entry and then waits on the registered RAM output; refused or empty-list
// operations go straight to the result. The result sits in an output
// register, so the next beat is taken while it waits on rsp_tready.

module indexed_list_store
   import ils_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // position[15:0], handle[47:16]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_value[31:0], found_position[36:32], hit[37], entry_count[42:38],
   // status[44:43], zero[47:45]
   output logic [47:0] rsp_tdata
);

   ils_item_type        item;
   ils_rsp_type         result;
   ils_mem_req_type     mem_req;
   logic [HANDLE_W-1:0] rdata;
   logic                done;
   logic                out_free;
   logic                rsp_valid_ff;
   ils_rsp_type         rsp_data_ff;

   assign item.op       = ils_op_type'(req_tuser);
   assign item.position = $signed(req_tdata[POS_W-1:0]);
   assign item.handle   = req_tdata[POS_W +: HANDLE_W];

   assign out_free = !rsp_valid_ff || rsp_tready;

   ils_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .item       (item),
      .out_free   (out_free),
      .done       (done),
      .result     (result),
      .mem_req    (mem_req),
      .rdata      (rdata)
   );

   ils_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_data_ff.status,
                        rsp_data_ff.entry_count,
                        rsp_data_ff.hit,
                        rsp_data_ff.found_position,
                        rsp_data_ff.read_value};

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

import ils_pkg::*;

class list_shadow;
   logic [HANDLE_W-1:0] handles[$];
   ils_rsp_type         pending_results[$];
   int mismatches;
   int checked;
   int op_seen[4];
   int refused;
   int empty_ops;
   int find_hits;

   function int size();
      return handles.size();
   endfunction

   function int clamp_existing(int p);
      if (p <= 0) return 0;
      if (p >= handles.size()) return handles.size() - 1;
      return p;
   endfunction

   // work out the response for one accepted request and update the shadow list
   function void note_request(ils_op_type op, logic signed [POS_W-1:0] pos,
                              logic [HANDLE_W-1:0] h);
      ils_rsp_type r;
      int p;
      int n;
      int at;
      p = pos;
      n = handles.size();
      r = '0;
      r.status = ST_OK;
      op_seen[op]++;
      if (op == OP_INSERT) begin
         if (n >= DEPTH) begin
            r.status = ST_FULL;
            refused++;
         end else begin
            at = (p <= 0) ? 0 : ((p >= n) ? n : p);
            handles.insert(at, h);
         end
      end else if (n == 0) begin
         r.status = ST_EMPTY;
         empty_ops++;
         if (op == OP_FIND) r.found_position = '1;
      end else begin
         case (op)
            OP_REMOVE: begin
               handles.delete(clamp_existing(p));
            end
            OP_READ: begin
               r.read_value = handles[clamp_existing(p)];
               r.hit = 1'b1;
            end
            default: begin
               r.found_position = '1;
               for (int i = 0; i < n; i++) begin
                  if (handles[i] == h) begin
                     r.found_position = i[FOUND_W-1:0];
                     r.hit = 1'b1;
                     find_hits++;
                     break;
                  end
               end
            end
         endcase
      end
      r.entry_count = COUNT_OUT_W'(handles.size());
      pending_results.push_back(r);
   endfunction

   function void check_response(logic [47:0] beat);
      ils_rsp_type got;
      ils_rsp_type want;
      got.read_value     = beat[31:0];
      got.found_position = beat[36:32];
      got.hit            = beat[37];
      got.entry_count    = beat[42:38];
      got.status         = ils_status_type'(beat[44:43]);
      checked++;
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected response beat %h at %0t", beat, $realtime);
         return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value || got.found_position !== want.found_position
          || got.hit !== want.hit || got.entry_count !== want.entry_count
          || got.status !== want.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"ERROR: response %0d at %0t: value %h/%h found %0d/%0d hit %b/%b",
                      " count %0d/%0d status %s/%s (expected/actual)"},
                     checked, $realtime, want.read_value, got.read_value,
                     $signed(want.found_position), $signed(got.found_position),
                     want.hit, got.hit, want.entry_count, got.entry_count,
                     want.status.name(), got.status.name());
      end
   endfunction
endclass

module tb_top;

   localparam int RANDOM_ITEMS = 1100;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_START   = 3000;
   localparam int HOLD_CYCLES  = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // position[15:0], handle[47:16]
   logic [1:0]  req_tuser;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   // read_value[31:0], found_position[36:32], hit[37], entry_count[42:38],
   // status[44:43], zero[47:45]
   logic [47:0] rsp_tdata;

   list_shadow shadow;
   bit quiet;
   int stall_cycles;
   logic [HANDLE_W-1:0] handle_pool[8];

   indexed_list_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic send_item(input ils_op_type op, input logic signed [POS_W-1:0] pos,
                            input logic [HANDLE_W-1:0] h);
      while (!quiet && $urandom_range(0, 99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {h, pos};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic ils_op_type pick_op(bit filling);
      int r;
      r = $urandom_range(0, 99);
      if (filling) begin
         if (r < 60) return OP_INSERT;
         if (r < 70) return OP_REMOVE;
         if (r < 85) return OP_READ;
         return OP_FIND;
      end
      if (r < 15) return OP_INSERT;
      if (r < 60) return OP_REMOVE;
      if (r < 80) return OP_READ;
      return OP_FIND;
   endfunction

   function automatic logic signed [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return POS_W'($urandom_range(0, 20) - 2);
      if (r < 85) begin
         case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd1;
            default: return 16'sd0;
         endcase
      end
      return POS_W'($urandom);
   endfunction

   function automatic logic [HANDLE_W-1:0] pick_handle(ils_op_type op);
      // find mostly looks for handles from the pool, which inserts also draw on
      if ($urandom_range(0, 99) < ((op == OP_FIND) ? 80 : 60))
         return handle_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // response side: random backpressure, one long hold-off to fill the block up
   initial begin
      int cyc;
      cyc = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) cyc++;
         if (cyc == HOLD_START) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= 22);
         end
      end
   end

   // check responses before noting new requests, both on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            shadow.check_response(rsp_tdata);
         if (req_tvalid && req_tready)
            shadow.note_request(ils_op_type'(req_tuser), req_tdata[15:0], req_tdata[47:16]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      ils_op_type op;
      bit filling;
      shadow = new();
      quiet = 1'b0;
      filling = 1'b1;
      handle_pool[0] = '0;
      handle_pool[1] = '1;
      for (int i = 2; i < 8; i++) handle_pool[i] = $urandom;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_INSERT;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list, clamping at both ends, middle insert, first-match find
      send_item(OP_REMOVE, 16'sd0,      32'h0);
      send_item(OP_READ,   16'sd3,      32'h0);
      send_item(OP_FIND,   16'sd0,      32'h0);
      send_item(OP_INSERT, 16'sh8000,   32'h0);
      send_item(OP_INSERT, 16'sh7fff,   32'hffff_ffff);
      send_item(OP_INSERT, 16'sd1,      32'h5a5a_5a5a);
      send_item(OP_INSERT, 16'sd0,      32'ha5a5_a5a5);
      send_item(OP_READ,   16'sh8000,   32'h0);
      send_item(OP_READ,   16'sh7fff,   32'h0);
      send_item(OP_READ,   16'sd2,      32'h0);
      send_item(OP_FIND,   16'sd0,      32'hffff_ffff);
      send_item(OP_FIND,   16'sd0,      32'h1234_5678);
      send_item(OP_INSERT, -16'sd1,     32'hffff_ffff);
      send_item(OP_FIND,   16'sh7fff,   32'hffff_ffff);
      send_item(OP_REMOVE, 16'sh7fff,   32'h0);
      send_item(OP_REMOVE, 16'sh8000,   32'h0);
      send_item(OP_REMOVE, 16'sd1,      32'h0);
      send_item(OP_FIND,   16'sd0,      32'h0);

      // alternate fill and drain so full and empty lists both come up often
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 500 && n < 650);
         if (filling && shadow.size() >= DEPTH && $urandom_range(0, 3) == 0)
            filling = 1'b0;
         else if (!filling && shadow.size() == 0 && $urandom_range(0, 2) == 0)
            filling = 1'b1;
         op = pick_op(filling);
         send_item(op, pick_position(), pick_handle(op));
      end
      quiet = 1'b0;
      req_tvalid <= 1'b0;

      while (shadow.pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display({"covered %0d inserts (%0d refused on a full list), %0d removes,",
                " %0d reads, %0d finds"},
               shadow.op_seen[OP_INSERT], shadow.refused, shadow.op_seen[OP_REMOVE],
               shadow.op_seen[OP_READ], shadow.op_seen[OP_FIND]);
      $display("%0d responses checked, %0d on an empty list, %0d finds matched, %0d mismatches",
               shadow.checked, shadow.empty_ops, shadow.find_hits, shadow.mismatches);
      if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
